### rtl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// tga_rle_pkg: shared types and constants of the TGA truecolor line decoder
// Item types, the configuration bundle, register addresses and depth codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_rle_pkg;

    // Register byte addresses are 4*index; the index sits in paddr[4:2].
    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_DEPTH     = 3'd0;
    localparam logic [2:0] REG_RLE_MODE  = 3'd1;
    localparam logic [2:0] REG_ALPHA_EN  = 3'd2;
    localparam logic [2:0] REG_MIRROR_X  = 3'd3;
    localparam logic [2:0] REG_LINE_WID  = 3'd4;

    localparam logic [1:0] DEPTH_15 = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    localparam logic [1:0]  RST_DEPTH      = DEPTH_24;
    localparam logic        RST_RLE_MODE   = 1'b1;
    localparam logic        RST_ALPHA_EN   = 1'b0;
    localparam logic        RST_MIRROR_X   = 1'b0;
    localparam logic [11:0] RST_LINE_WIDTH = 12'd640;

    localparam int unsigned MAX_WIDTH_DEF = 2048;
    // Largest width the 12-bit line length register can express.
    localparam int unsigned LINE_REG_MAX  = 4095;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [10:0] x_start;
        logic [7:0]  run_length;
        logic        last_in_line;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  pixel_depth_code;
        logic        rle_mode;
        logic        alpha_enable;
        logic        mirror_x;
        logic [11:0] line_pixels;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/tga_rle_cfg.sv
// ----------------------------------------------------------------------------
// tga_rle_cfg: configuration register bank
// APB-style write and read access to the five decoder registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_cfg
    import tga_rle_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [ADDR_W-1:0] paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_depth_code <= RST_DEPTH;
            cfg_reg.rle_mode         <= RST_RLE_MODE;
            cfg_reg.alpha_enable     <= RST_ALPHA_EN;
            cfg_reg.mirror_x         <= RST_MIRROR_X;
            cfg_reg.line_pixels      <= RST_LINE_WIDTH;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_DEPTH:    cfg_reg.pixel_depth_code <= pwdata[1:0];
                REG_RLE_MODE: cfg_reg.rle_mode         <= pwdata[0];
                REG_ALPHA_EN: cfg_reg.alpha_enable     <= pwdata[0];
                REG_MIRROR_X: cfg_reg.mirror_x         <= pwdata[0];
                REG_LINE_WID: cfg_reg.line_pixels      <= pwdata[11:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_DEPTH:    prdata = {30'd0, cfg_reg.pixel_depth_code};
            REG_RLE_MODE: prdata = {31'd0, cfg_reg.rle_mode};
            REG_ALPHA_EN: prdata = {31'd0, cfg_reg.alpha_enable};
            REG_MIRROR_X: prdata = {31'd0, cfg_reg.mirror_x};
            REG_LINE_WID: prdata = {20'd0, cfg_reg.line_pixels};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/tga_rle_color.sv
// ----------------------------------------------------------------------------
// tga_rle_color: pixel to 8-bit RGB conversion
// Expands 15/16-bit pixels, copies 24-bit ones and premultiplies 32-bit
// pixels by their alpha byte when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_color
    import tga_rle_pkg::*;
(
    input  wire  [31:0] pixel,
    input  wire  [1:0]  depth,
    input  wire         alpha_enable,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    // Rounded c*a/255 approximation.
    function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] t;
        logic [16:0] s;
        t = 16'(16'(c) * 16'(a) + 16'd128);
        s = 17'(t) + 17'(t[15:8]);
        return s[15:8];
    endfunction

    logic [15:0] v16;

    assign v16 = pixel[15:0];

    always_comb
    begin
        if (depth == DEPTH_15 || depth == DEPTH_16)
        begin
            red   = {v16[14:10], 3'b000};
            green = {v16[9:5], 3'b000};
            blue  = {v16[4:0], 3'b000};
        end
        else if (depth == DEPTH_32 && alpha_enable)
        begin
            red   = premul(pixel[23:16], pixel[31:24]);
            green = premul(pixel[15:8], pixel[31:24]);
            blue  = premul(pixel[7:0], pixel[31:24]);
        end
        else
        begin
            red   = pixel[23:16];
            green = pixel[15:8];
            blue  = pixel[7:0];
        end
    end

endmodule

`default_nettype wire

### rtl/tga_rle_parse.sv
// ----------------------------------------------------------------------------
// tga_rle_parse: packet parser and line position tracker
// Holds the parser state, gathers pixel bytes and forms one result item
// per completed pixel or run, clipped at the end of the line.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_parse
    import tga_rle_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            step,
    input  wire in_item_t  item,
    input  wire cfg_t      cfg,
    output logic           res_valid,
    output out_item_t      res
);

    localparam int unsigned WCAP = (MAX_WIDTH < LINE_REG_MAX) ? MAX_WIDTH : LINE_REG_MAX;
    localparam int unsigned XW   = $clog2(WCAP + 1);

    logic          expect_header_reg, expect_header_next;
    logic [1:0]    byte_index_reg, byte_index_next;
    logic [31:0]   pixel_bytes_reg, pixel_bytes_next;
    logic          packet_is_run_reg, packet_is_run_next;
    logic [7:0]    packet_remaining_reg, packet_remaining_next;
    logic [XW-1:0] x_position_reg, x_position_next;

    logic [31:0]   w32;
    logic [XW-1:0] w;
    logic [31:0]   pixel_merged;
    logic [7:0]    red, green, blue;

    assign w32 = (cfg.line_pixels == 12'd0) ? 32'd1 :
                 ((32'(cfg.line_pixels) > MAX_WIDTH) ? MAX_WIDTH : 32'(cfg.line_pixels));
    assign w   = w32[XW-1:0];

    tga_rle_color u_color (
        .pixel        (pixel_merged),
        .depth        (cfg.pixel_depth_code),
        .alpha_enable (cfg.alpha_enable),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    always_comb
    begin
        logic          cur_eh;
        logic [1:0]    cur_bi;
        logic [31:0]   cur_pb;
        logic          cur_run;
        logic [7:0]    cur_rem;
        logic [XW-1:0] cur_x;
        logic [XW-1:0] x1;
        logic [XW-1:0] room;
        logic [XW-1:0] xs;
        logic [XW-1:0] x_end;
        logic [1:0]    last_idx;
        logic [7:0]    len;
        logic [31:0]   xs32;

        // A restart clears the parser before the byte is looked at.
        cur_eh  = item.restart ? cfg.rle_mode : expect_header_reg;
        cur_bi  = item.restart ? 2'd0 : byte_index_reg;
        cur_pb  = item.restart ? 32'd0 : pixel_bytes_reg;
        cur_run = item.restart ? 1'b0 : packet_is_run_reg;
        cur_rem = item.restart ? 8'd0 : packet_remaining_reg;
        cur_x   = item.restart ? '0 : x_position_reg;

        pixel_merged = cur_pb;
        pixel_merged[{cur_bi, 3'b000} +: 8] = item.data_byte;
        last_idx = (cfg.pixel_depth_code == DEPTH_15 || cfg.pixel_depth_code == DEPTH_16)
                   ? 2'd1 : cfg.pixel_depth_code;

        expect_header_next    = cur_eh;
        byte_index_next       = cur_bi;
        pixel_bytes_next      = cur_pb;
        packet_is_run_next    = cur_run;
        packet_remaining_next = cur_rem;
        x_position_next       = cur_x;
        res_valid             = 1'b0;
        x1                    = cur_x;
        len                   = 8'd1;
        room                  = '0;
        xs                    = '0;
        x_end                 = '0;
        xs32                  = 32'd0;
        res                   = '0;

        if (cfg.rle_mode && (cur_eh || cur_rem == 8'd0))
        begin
            // Packet header: bit 7 marks a run, low bits hold count minus one.
            packet_is_run_next    = item.data_byte[7];
            packet_remaining_next = {1'b0, item.data_byte[6:0]} + 8'd1;
            expect_header_next    = 1'b0;
            byte_index_next       = 2'd0;
            pixel_bytes_next      = 32'd0;
            if (cur_x >= w)
            begin
                x_position_next = '0;
            end
        end
        else if (cur_bi < last_idx)
        begin
            byte_index_next  = cur_bi + 2'd1;
            pixel_bytes_next = pixel_merged;
        end
        else
        begin
            byte_index_next  = 2'd0;
            pixel_bytes_next = 32'd0;
            if (!cfg.rle_mode)
            begin
                if (cur_x >= w)
                begin
                    x1 = '0;
                end
            end
            else if (cur_run)
            begin
                len                   = cur_rem;
                packet_remaining_next = 8'd0;
                expect_header_next    = 1'b1;
            end
            else
            begin
                packet_remaining_next = cur_rem - 8'd1;
                if (cur_rem == 8'd1)
                begin
                    expect_header_next = 1'b1;
                end
            end
            x_position_next = x1;

            // Pixels past the line end are dropped until the next header.
            if (x1 < w)
            begin
                room = w - x1;
                if (32'(len) > 32'(room))
                begin
                    len = 8'(room);
                end
                xs    = cfg.mirror_x ? (w - XW'(1) - x1) : x1;
                xs32  = 32'(xs);
                x_end = x1 + XW'(len);
                res_valid        = 1'b1;
                res.red          = red;
                res.green        = green;
                res.blue         = blue;
                res.x_start      = xs32[10:0];
                res.run_length   = len;
                res.last_in_line = (x_end >= w);
                if (x_end >= w && !cfg.rle_mode)
                begin
                    x_position_next = '0;
                end
                else
                begin
                    x_position_next = x_end;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg    <= RST_RLE_MODE;
            byte_index_reg       <= 2'd0;
            pixel_bytes_reg      <= 32'd0;
            packet_is_run_reg    <= 1'b0;
            packet_remaining_reg <= 8'd0;
            x_position_reg       <= '0;
        end
        else if (step)
        begin
            expect_header_reg    <= expect_header_next;
            byte_index_reg       <= byte_index_next;
            pixel_bytes_reg      <= pixel_bytes_next;
            packet_is_run_reg    <= packet_is_run_next;
            packet_remaining_reg <= packet_remaining_next;
            x_position_reg       <= x_position_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tga_truecolor_rle_line_decoder.sv
// ----------------------------------------------------------------------------
// tga_truecolor_rle_line_decoder: TGA truecolor pixel stream decoder
// Parses raw or run-length coded pixel bytes and emits one color run item
// per completed pixel or run packet, with line position and end flag.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   src      in         src_valid/src_stall  in_item_t  (data_byte, restart)
//   dst      out        dst_valid/dst_stall  out_item_t (color, x, length, last)
//   apb      in/out     psel/penable/pready  five 32-bit registers
//
// One byte item is taken per clock while src_stall is low. An accepted item
// waits in the input register; the parser then writes its result into the
// output register once that register can take it. Header and partial-pixel
// bytes produce no result.
// A stall at dst holds the output register; the input register keeps taking
// items while a result waits, until both stages are full. Reset clears the
// parser and sets the registers to their defaults; no clearing pass.
//
`default_nettype none

module tga_truecolor_rle_line_decoder
    import tga_rle_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               src_valid,
    output logic              src_stall,
    input  wire in_item_t     src_data,
    output logic              dst_valid,
    input  wire               dst_stall,
    output out_item_t         dst_data,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [ADDR_W-1:0] paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    logic      fire;
    logic      src_take;
    logic      res_valid;
    out_item_t res;

    tga_rle_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held item is processed whenever the output register can take a result.
    assign fire      = in_valid_reg && (!out_valid_reg || !dst_stall);
    assign src_stall = in_valid_reg && !fire;
    assign src_take  = src_valid && !src_stall;

    tga_rle_parse #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .item      (in_item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (src_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= res_valid;
            end
            else if (out_valid_reg && !dst_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            in_item_reg <= src_data;
        end
        if (fire && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_item_reg;

    // A new result only ever comes from an item processed in the cycle before.
    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(fire))
        else $error("result appeared without a processed item");

    // Run lengths stay within one packet and are never empty.
    a_run_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_data.run_length != 8'd0 && dst_data.run_length <= 8'd128))
        else $error("run length out of range");

    // With both stages full and the output blocked, the source must be held off.
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && dst_valid && dst_stall) |-> (src_stall && !fire))
        else $error("item accepted while pipeline is full and blocked");

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the TGA truecolor line decoder
// Feeds raw and run-length coded pixel byte streams under random idling on
// both sides, predicts every color run in a local decoder model and checks
// each result field by field. Registers are set over APB between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tga_rle_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned RANDOM_BYTES = 1550;
    localparam int unsigned PHASE_BYTES  = 100;
    localparam int unsigned DRAIN_CYCLES = 4;

    logic              clk;
    logic              rst_n;
    logic              src_valid;
    logic              src_stall;
    in_item_t          src_data;
    logic              dst_valid;
    logic              dst_stall;
    out_item_t         dst_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    tga_truecolor_rle_line_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow of the registers and of the parser state.
    cfg_t        cfg_now;
    bit          hdr_due;
    logic [1:0]  byte_idx;
    logic [31:0] pix_acc;
    bit          pkt_is_run;
    int unsigned pkt_left;
    int unsigned x_pos;

    out_item_t   pending_runs[$];
    int unsigned bytes_sent;
    int unsigned runs_seen;
    int unsigned settings_done;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    bit          src_gaps_on;
    bit          dst_stalls_on;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 30)
            $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    endtask

    function automatic void clear_parser();
        hdr_due    = cfg_now.rle_mode;
        byte_idx   = '0;
        pix_acc    = '0;
        pkt_is_run = 1'b0;
        pkt_left   = 0;
        x_pos      = 0;
    endfunction

    function automatic logic [7:0] premultiply(input logic [7:0] c, input logic [7:0] a);
        int unsigned t;
        t = (c * a + 128) & 16'hFFFF;
        return 8'((t + (t >> 8)) >> 8);
    endfunction

    // Advances the parser shadow by one byte item; returns 1 with the color
    // run when the byte completes a pixel that lands inside the line.
    function automatic bit decode_byte(input in_item_t it, output out_item_t run);
        int unsigned wdt;
        int unsigned last_idx;
        int unsigned len;
        int unsigned xs;
        bit          coded;
        logic [15:0] v;

        run = '0;
        wdt = 32'(cfg_now.line_pixels);
        if (wdt == 0)
            wdt = 1;
        if (wdt > MAX_WIDTH_DEF)
            wdt = MAX_WIDTH_DEF;
        if (it.restart)
            clear_parser();
        coded = cfg_now.rle_mode;

        if (coded && (hdr_due || pkt_left == 0)) begin
            pkt_is_run = it.data_byte[7];
            pkt_left   = it.data_byte[6:0] + 1;
            hdr_due    = 1'b0;
            byte_idx   = '0;
            pix_acc    = '0;
            if (x_pos >= wdt)
                x_pos = 0;
            return 1'b0;
        end

        pix_acc[8*byte_idx +: 8] = it.data_byte;
        last_idx = (cfg_now.pixel_depth_code <= DEPTH_16) ? 1 : cfg_now.pixel_depth_code;
        // A depth lowered in mid-pixel completes the pixel at once.
        if (byte_idx < last_idx) begin
            byte_idx++;
            return 1'b0;
        end
        byte_idx = '0;

        if (!coded) begin
            if (x_pos >= wdt)
                x_pos = 0;
            len = 1;
        end
        else if (pkt_is_run) begin
            len      = pkt_left;
            pkt_left = 0;
            hdr_due  = 1'b1;
        end
        else begin
            len      = 1;
            pkt_left = pkt_left - 1;
            if (pkt_left == 0)
                hdr_due = 1'b1;
        end

        // Pixels past the line end are dropped until the next header.
        if (x_pos >= wdt) begin
            pix_acc = '0;
            return 1'b0;
        end
        if (len > wdt - x_pos)
            len = wdt - x_pos;

        if (cfg_now.pixel_depth_code <= DEPTH_16) begin
            v         = pix_acc[15:0];
            run.blue  = {v[4:0], 3'b000};
            run.green = {v[9:5], 3'b000};
            run.red   = {v[14:10], 3'b000};
        end
        else if (cfg_now.pixel_depth_code == DEPTH_32 && cfg_now.alpha_enable) begin
            run.red   = premultiply(pix_acc[23:16], pix_acc[31:24]);
            run.green = premultiply(pix_acc[15:8], pix_acc[31:24]);
            run.blue  = premultiply(pix_acc[7:0], pix_acc[31:24]);
        end
        else begin
            run.red   = pix_acc[23:16];
            run.green = pix_acc[15:8];
            run.blue  = pix_acc[7:0];
        end
        pix_acc = '0;

        xs = cfg_now.mirror_x ? (wdt - 1 - x_pos) : x_pos;
        run.x_start    = xs[10:0];
        run.run_length = len[7:0];
        x_pos += len;
        run.last_in_line = (x_pos >= wdt);
        if (run.last_in_line && !coded)
            x_pos = 0;
        return 1'b1;
    endfunction

    task automatic check_run(input out_item_t got);
        out_item_t want;
        if (pending_runs.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(got.run_length), 0);
            return;
        end
        want = pending_runs.pop_front();
        runs_seen++;
        if (got.red !== want.red)
            report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
            report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
            report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.x_start !== want.x_start)
            report_mismatch("x_start", 32'(got.x_start), 32'(want.x_start));
        if (got.run_length !== want.run_length)
            report_mismatch("run_length", 32'(got.run_length), 32'(want.run_length));
        if (got.last_in_line !== want.last_in_line)
            report_mismatch("last_in_line", 32'(got.last_in_line), 32'(want.last_in_line));
    endtask

    always @(posedge clk)
    begin
        out_item_t run;
        if (rst_n && src_valid && !src_stall) begin
            if (decode_byte(src_data, run))
                pending_runs.push_back(run);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            check_run(dst_data);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver back-pressure: random stalls, short mostly, some long.
    initial begin
        dst_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (dst_stalls_on && $urandom_range(0, 5) == 0) begin
                dst_stall <= 1'b1;
                repeat (pause_len() + 1) @(posedge clk);
                dst_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic restart);
        in_item_t    it;
        int unsigned gap;
        it.data_byte = data;
        it.restart   = restart;
        src_data  <= it;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        bytes_sent++;
        gap = src_gaps_on ? pause_len() : 0;
        if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_runs();
        src_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
    endtask

    // Header and partial-pixel bytes give no result, so after the last run
    // the pipeline may still hold such a byte.
    task automatic settle();
        drain_runs();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic [2:0] idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        write_reg(idx, value);
        read_reg(idx, readback);
        if (readback !== value)
            report_mismatch($sformatf("readback of register %0d", idx), readback, value);
        case (idx)
            REG_DEPTH:    cfg_now.pixel_depth_code = value[1:0];
            REG_RLE_MODE: cfg_now.rle_mode         = value[0];
            REG_ALPHA_EN: cfg_now.alpha_enable     = value[0];
            REG_MIRROR_X: cfg_now.mirror_x         = value[0];
            REG_LINE_WID: cfg_now.line_pixels      = value[11:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] depth, input logic rle, input logic alpha,
                              input logic mirror, input logic [11:0] width);
        settle();
        program_reg(REG_DEPTH, 32'(depth));
        program_reg(REG_RLE_MODE, 32'(rle));
        program_reg(REG_ALPHA_EN, 32'(alpha));
        program_reg(REG_MIRROR_X, 32'(mirror));
        program_reg(REG_LINE_WID, 32'(width));
        settings_done++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pixel_bytes_now();
        return (cfg_now.pixel_depth_code <= DEPTH_16) ? 2 : cfg_now.pixel_depth_code + 1;
    endfunction

    task automatic send_pixel();
        int unsigned n;
        n = pixel_bytes_now();
        repeat (n) send_byte(pick_byte(), 1'b0);
    endtask

    // One coded packet with random content; now and then it is cut short.
    task automatic send_packet();
        int unsigned r;
        int unsigned count;
        int unsigned npix;
        bit          is_run;
        r = $urandom_range(0, 9);
        if (r < 7)
            count = $urandom_range(1, 6);
        else if (r < 9)
            count = $urandom_range(7, 40);
        else
            count = 128;
        is_run = ($urandom_range(0, 1) != 0);
        send_byte({is_run, 7'(count - 1)}, $urandom_range(0, 29) == 0);
        npix = is_run ? 1 : count;
        if ($urandom_range(0, 11) == 0)
            npix = $urandom_range(0, npix);
        repeat (npix) send_pixel();
    endtask

    task automatic test_register_defaults();
        logic [31:0] value;
        read_reg(REG_DEPTH, value);
        if (value !== 32'(RST_DEPTH))
            report_mismatch("reset depth", value, 32'(RST_DEPTH));
        read_reg(REG_RLE_MODE, value);
        if (value !== 32'(RST_RLE_MODE))
            report_mismatch("reset rle_mode", value, 32'(RST_RLE_MODE));
        read_reg(REG_ALPHA_EN, value);
        if (value !== 32'(RST_ALPHA_EN))
            report_mismatch("reset alpha_enable", value, 32'(RST_ALPHA_EN));
        read_reg(REG_MIRROR_X, value);
        if (value !== 32'(RST_MIRROR_X))
            report_mismatch("reset mirror_x", value, 32'(RST_MIRROR_X));
        read_reg(REG_LINE_WID, value);
        if (value !== 32'(RST_LINE_WIDTH))
            report_mismatch("reset line_pixels", value, 32'(RST_LINE_WIDTH));
    endtask

    // Reset settings: 24-bit coded stream, one run and one raw pixel.
    task automatic test_coded_truecolor();
        send_byte(8'h82, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
    endtask

    // Uncompressed 15-bit pixels on a one-pixel mirrored line.
    task automatic test_raw_single_column();
        set_config(DEPTH_15, 1'b0, 1'b0, 1'b1, 12'd1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // A 128-pixel run clipped at a 2-pixel line, alpha at full and zero, and
    // a depth lowered while a 32-bit pixel is half gathered.
    task automatic test_alpha_clip_depth_switch();
        set_config(DEPTH_32, 1'b1, 1'b1, 1'b0, 12'd2);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        set_config(DEPTH_15, 1'b1, 1'b0, 1'b0, 12'd2);
        send_byte(8'h56, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned start;
        int unsigned r;
        logic [11:0] width;
        logic        rle;
        bit          paused;

        phase = 0;
        while (bytes_sent < RANDOM_BYTES - PHASE_BYTES / 2) begin
            case (phase)
                0:       width = 12'd2048;
                1:       width = 12'd1;
                2:       width = 12'd0;
                3:       width = 12'd4095;
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        width = 12'($urandom_range(2, 40));
                    else if (r < 9)
                        width = 12'($urandom_range(41, 300));
                    else
                        width = 12'($urandom_range(301, 4095));
                end
            endcase
            rle = (phase % 5 != 4);
            set_config(phase[1:0], rle, phase[2], phase[3] ^ phase[0], width);
            src_gaps_on   = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            dst_stalls_on = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);

            start  = bytes_sent;
            paused = 1'b0;
            // A phase may begin mid-packet, or restart the parser cleanly.
            if ($urandom_range(0, 1) == 0)
                send_byte(pick_byte(), 1'b1);
            while (bytes_sent - start < PHASE_BYTES) begin
                if (!paused && bytes_sent - start >= PHASE_BYTES / 2) begin
                    paused = 1'b1;
                    if (phase == 1 || $urandom_range(0, 2) == 0)
                        drain_runs();
                end
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_byte(pick_byte(), $urandom_range(0, 7) == 0);
                else if (!rle)
                    send_pixel();
                else
                    send_packet();
            end
            phase++;
        end
    endtask

    initial begin
        rst_n         <= 1'b0;
        src_valid     <= 1'b0;
        src_data      <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        bytes_sent    = 0;
        runs_seen     = 0;
        settings_done = 0;
        mismatches    = 0;
        src_gaps_on   = 1'b1;
        dst_stalls_on = 1'b1;
        cfg_now.pixel_depth_code = RST_DEPTH;
        cfg_now.rle_mode         = RST_RLE_MODE;
        cfg_now.alpha_enable     = RST_ALPHA_EN;
        cfg_now.mirror_x         = RST_MIRROR_X;
        cfg_now.line_pixels      = RST_LINE_WIDTH;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_coded_truecolor();
        test_raw_single_column();
        test_alpha_clip_depth_switch();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (pending_runs.size() != 0)
            report_mismatch("runs never delivered", pending_runs.size(), 0);

        $display("Decoded %0d bytes into %0d color runs across %0d register settings,",
                 bytes_sent, runs_seen, settings_done);
        $display("covering all depths, coded and raw streams, alpha, mirroring, widths 0..4095.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/tga_rle_pkg.sv
rtl/tga_rle_cfg.sv
rtl/tga_rle_color.sv
rtl/tga_rle_parse.sv
rtl/tga_truecolor_rle_line_decoder.sv
dv/tb_top.sv
